@@ rtl/core/rsc_pkg.sv @@
// shared types, widths and helper functions for the return covariance block
package rsc_pkg;

    localparam int PRICE_W = 32;
    localparam int RET_W   = 32;
    localparam int SUM_W   = 44;
    localparam int COV_W   = 64;
    localparam int PAIRS_W = 11;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

    typedef struct packed {
        logic                    sat;
        logic signed [RET_W-1:0] val;
    } t_ret_res;

    typedef struct packed {
        logic                    sat;
        logic signed [SUM_W-1:0] val;
    } t_sum_res;

    // quotient magnitude to saturated signed return
    function automatic t_ret_res ret_fix(input logic [RET_W-1:0] q, input logic dn,
                                         input logic over);
        t_ret_res res;
        if (!dn) begin
            res.sat = over | q[RET_W-1];
            res.val = res.sat ? {1'b0, {(RET_W-1){1'b1}}} : q;
        end else begin
            res.sat = over | (q[RET_W-1] & (|q[RET_W-2:0]));
            res.val = res.sat ? {1'b1, {(RET_W-1){1'b0}}} : -q;
        end
        return res;
    endfunction

    // saturating add of a return into a running sum
    function automatic t_sum_res sum_add(input logic signed [SUM_W-1:0] s,
                                         input logic signed [RET_W-1:0] r);
        t_sum_res res;
        logic signed [SUM_W:0] t;
        t = {s[SUM_W-1], s} + {{(SUM_W+1-RET_W){r[RET_W-1]}}, r};
        if (t[SUM_W] != t[SUM_W-1]) begin
            res.sat = 1'b1;
            res.val = t[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            res.sat = 1'b0;
            res.val = t[SUM_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rsc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module rsc_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ rtl/core/rsc_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module rsc_div #(
    parameter int QW = 32,
    parameter int VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int CNTW = $clog2(QW + 1);

    logic [VW-1:0]   r_rem;
    logic [QW-1:0]   r_quo;
    logic [VW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [VW:0]     t;
    logic [VW:0]     d;
    logic            ge;

    assign t  = {r_rem, r_quo[QW-1]};
    assign ge = (t >= {1'b0, r_den});
    assign d  = t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? d[VW-1:0] : t[VW-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ rtl/core/return_series_covariance.sv @@
// top level: covariance of simple returns of two price series
//
// channel   direction  signals                                   handshake
// -------   ---------  ----------------------------------------  --------------------
// item in   input      i_price_a, i_price_b, i_last_sample       start & !busy
// result    output     o_covariance, o_pairs_used, o_overflowed  o_valid, one cycle
//
// an ordinary item is accepted, run through the two parallel return dividers
// (one quotient bit a cycle), handed off and then stored and summed
// a last item adds two mean divisions, a pass over the n stored return pairs
// (one ram read a cycle) and the final divide by n; the long divider is
// ACCW = 65 + log2(MAX_SAMPLES) bits wide
// reset is synchronous, active low; the return stores need no clearing pass
// the result is shown for exactly one cycle with o_valid; the receiver cannot stall
module return_series_covariance #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rsc_pkg::PRICE_W-1:0]       i_price_a,
    input  logic [rsc_pkg::PRICE_W-1:0]       i_price_b,
    input  logic                              i_last_sample,
    output logic                              o_valid,
    output logic signed [rsc_pkg::COV_W-1:0]  o_covariance,
    output logic [rsc_pkg::PAIRS_W-1:0]       o_pairs_used,
    output logic                              o_overflowed
);
    import rsc_pkg::*;

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int ACCW = 64 + AW + 1;   // magnitude of the product sum
    localparam int SACW = ACCW + 1;      // signed product sum

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RET   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_MEANA = 3'd3;
    localparam logic [2:0] S_MEANB = 3'd4;
    localparam logic [2:0] S_PASS  = 3'd5;
    localparam logic [2:0] S_COV   = 3'd6;

    logic [2:0] r_state;

    // per-item latched info
    logic r_dn_a, r_dn_b, r_ov_a, r_ov_b, r_has_a, r_has_b, r_last;

    // series state
    logic [PRICE_W-1:0]      r_prev_a, r_prev_b;
    logic [CW-1:0]           r_cnt_a, r_cnt_b;
    logic signed [SUM_W-1:0] r_sum_a, r_sum_b;
    logic                    r_sat;

    // covariance pass
    logic signed [RET_W:0]   r_mean_a, r_mean_b;
    logic [CW-1:0]           r_n, r_idx;
    logic                    r_p1, r_p2, r_p3;
    logic [RET_W-1:0]        r_ma, r_mb;
    logic                    r_xn, r_pn;
    logic [63:0]             r_prod;
    logic signed [SACW-1:0]  r_acc;

    // shared long divider feed
    logic                    r_ld_go;
    logic [ACCW-1:0]         r_ld_num;
    logic [CW-1:0]           r_ld_den;
    logic                    r_ld_neg;

    // result registers
    logic                    r_valid;
    logic signed [COV_W-1:0] r_cov;
    logic [PAIRS_W-1:0]      r_pairs;
    logic                    r_ovf;

    logic accept;
    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // return dividers, started on accept
    logic [PRICE_W-1:0] mag_a, mag_b;
    logic               dn_a, dn_b;
    logic               ra_done, rb_done;
    logic [RET_W-1:0]   ra_q, rb_q;

    assign dn_a  = (i_price_a < r_prev_a);
    assign dn_b  = (i_price_b < r_prev_b);
    assign mag_a = dn_a ? (r_prev_a - i_price_a) : (i_price_a - r_prev_a);
    assign mag_b = dn_b ? (r_prev_b - i_price_b) : (i_price_b - r_prev_b);

    // dividend is mag << 30; top 30 bits preload the remainder
    rsc_div #(.QW(RET_W), .VW(PRICE_W)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_rem   ({2'b00, mag_a[PRICE_W-1:2]}),
        .i_num   ({mag_a[1:0], 30'd0}),
        .i_den   (r_prev_a),
        .o_done  (ra_done),
        .o_quo   (ra_q)
    );

    rsc_div #(.QW(RET_W), .VW(PRICE_W)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_rem   ({2'b00, mag_b[PRICE_W-1:2]}),
        .i_num   ({mag_b[1:0], 30'd0}),
        .i_den   (r_prev_b),
        .o_done  (rb_done),
        .o_quo   (rb_q)
    );

    // long divider: both means, then the covariance
    logic            ld_done;
    logic [ACCW-1:0] ld_q;

    rsc_div #(.QW(ACCW), .VW(CW)) u_div_long (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ld_go),
        .i_rem   ({CW{1'b0}}),
        .i_num   (r_ld_num),
        .i_den   (r_ld_den),
        .o_done  (ld_done),
        .o_quo   (ld_q)
    );

    // return stores
    logic                we_a, we_b;
    logic [RET_W-1:0]    rd_a, rd_b;
    t_ret_res            ret_a, ret_b;

    rsc_ram #(.W(RET_W), .DEPTH(MAX_SAMPLES)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (ret_a.val),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_a)
    );

    rsc_ram #(.W(RET_W), .DEPTH(MAX_SAMPLES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (ret_b.val),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_b)
    );

    // store step: saturate returns, append, update sums and flags
    t_sum_res                sa, sb;
    logic                    full_a, full_b;
    logic [CW-1:0]           n_cnt_a, n_cnt_b, n_min;
    logic signed [SUM_W-1:0] n_sum_a, n_sum_b;
    logic                    n_sat;

    always_comb begin
        ret_a   = ret_fix(ra_q, r_dn_a, r_ov_a);
        ret_b   = ret_fix(rb_q, r_dn_b, r_ov_b);
        full_a  = (r_cnt_a == CW'(MAX_SAMPLES));
        full_b  = (r_cnt_b == CW'(MAX_SAMPLES));
        sa      = sum_add(r_sum_a, ret_a.val);
        sb      = sum_add(r_sum_b, ret_b.val);
        we_a    = (r_state == S_STORE) && r_has_a && !full_a;
        we_b    = (r_state == S_STORE) && r_has_b && !full_b;
        n_cnt_a = we_a ? r_cnt_a + 1'b1 : r_cnt_a;
        n_cnt_b = we_b ? r_cnt_b + 1'b1 : r_cnt_b;
        n_sum_a = we_a ? sa.val : r_sum_a;
        n_sum_b = we_b ? sb.val : r_sum_b;
        n_min   = (n_cnt_a < n_cnt_b) ? n_cnt_a : n_cnt_b;
        n_sat   = r_sat
                | (r_has_a & (ret_a.sat | full_a | (!full_a & sa.sat)))
                | (r_has_b & (ret_b.sat | full_b | (!full_b & sb.sat)));
    end

    // deviation from mean, magnitude fits 32 bits
    logic signed [RET_W+1:0] dev_a, dev_b, ndev_a, ndev_b;
    always_comb begin
        dev_a  = {{2{rd_a[RET_W-1]}}, rd_a} - {r_mean_a[RET_W], r_mean_a};
        dev_b  = {{2{rd_b[RET_W-1]}}, rd_b} - {r_mean_b[RET_W], r_mean_b};
        ndev_a = -dev_a;
        ndev_b = -dev_b;
    end

    // magnitude of a sum for the mean division; series a includes the last item
    logic [SUM_W-1:0] abs_a, abs_b;
    assign abs_a = n_sum_a[SUM_W-1] ? SUM_W'(-n_sum_a) : n_sum_a;
    assign abs_b = r_sum_b[SUM_W-1] ? SUM_W'(-r_sum_b) : r_sum_b;

    // signed mean from the quotient
    logic signed [RET_W:0] mean_q;
    assign mean_q = r_ld_neg ? -ld_q[RET_W:0] : ld_q[RET_W:0];

    // product-sum magnitude
    logic signed [SACW-1:0] nacc;
    logic                   acc_neg;
    assign nacc    = -r_acc;
    assign acc_neg = r_acc[SACW-1];

    // final saturation of the covariance
    logic                    q_hi, cov_sat;
    logic signed [COV_W-1:0] cov_val;
    always_comb begin
        q_hi = |ld_q[ACCW-1:COV_W];
        if (!r_ld_neg) begin
            cov_sat = q_hi | ld_q[COV_W-1];
            cov_val = cov_sat ? COV_MAX : ld_q[COV_W-1:0];
        end else begin
            cov_sat = q_hi | (ld_q[COV_W-1] & (|ld_q[COV_W-2:0]));
            cov_val = (cov_sat | ld_q[COV_W-1]) ? COV_MIN : -ld_q[COV_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev_a <= '0;
            r_prev_b <= '0;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_sat    <= 1'b0;
            r_ld_go  <= 1'b0;
            r_valid  <= 1'b0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_p3     <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_ld_go <= 1'b0;
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prev_a <= i_price_a;
                        r_prev_b <= i_price_b;
                        r_state  <= S_RET;
                    end
                end
                S_RET: begin
                    if (ra_done && rb_done) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_cnt_a <= n_cnt_a;
                    r_cnt_b <= n_cnt_b;
                    r_sum_a <= n_sum_a;
                    r_sum_b <= n_sum_b;
                    r_sat   <= n_sat;
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (n_min == '0) begin
                        // no return pairs: zero result, clear and go idle
                        r_valid  <= 1'b1;
                        r_prev_a <= '0;
                        r_prev_b <= '0;
                        r_cnt_a  <= '0;
                        r_cnt_b  <= '0;
                        r_sum_a  <= '0;
                        r_sum_b  <= '0;
                        r_sat    <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_ld_go <= 1'b1;
                        r_state <= S_MEANA;
                    end
                end
                S_MEANA: begin
                    if (ld_done) begin
                        r_ld_go <= 1'b1;
                        r_state <= S_MEANB;
                    end
                end
                S_MEANB: begin
                    if (ld_done) begin
                        r_idx   <= '0;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_p2 <= r_p1;
                    r_p3 <= r_p2;
                    if (r_idx != r_n) begin
                        r_idx <= r_idx + 1'b1;
                        r_p1  <= 1'b1;
                    end else begin
                        r_p1 <= 1'b0;
                        if (!r_p1 && !r_p2 && !r_p3) begin
                            r_ld_go <= 1'b1;
                            r_state <= S_COV;
                        end
                    end
                end
                S_COV: begin
                    if (ld_done) begin
                        r_valid  <= 1'b1;
                        r_prev_a <= '0;
                        r_prev_b <= '0;
                        r_cnt_a  <= '0;
                        r_cnt_b  <= '0;
                        r_sum_a  <= '0;
                        r_sum_b  <= '0;
                        r_sat    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dn_a  <= dn_a;
            r_dn_b  <= dn_b;
            r_ov_a  <= ({2'b00, mag_a} >= {r_prev_a, 2'b00});
            r_ov_b  <= ({2'b00, mag_b} >= {r_prev_b, 2'b00});
            r_has_a <= (r_prev_a != '0);
            r_has_b <= (r_prev_b != '0);
            r_last  <= i_last_sample;
        end

        case (r_state)
            S_STORE: begin
                r_n      <= n_min;
                r_ld_num <= {{(ACCW-SUM_W){1'b0}}, abs_a};
                r_ld_den <= n_cnt_a;
                r_ld_neg <= n_sum_a[SUM_W-1];
                r_cov    <= '0;
                r_pairs  <= PAIRS_W'(n_min);
                r_ovf    <= n_sat;
            end
            S_MEANA: begin
                if (ld_done) begin
                    r_mean_a <= mean_q;
                    r_ld_num <= {{(ACCW-SUM_W){1'b0}}, abs_b};
                    r_ld_den <= r_cnt_b;
                    r_ld_neg <= r_sum_b[SUM_W-1];
                end
            end
            S_MEANB: begin
                if (ld_done) begin
                    r_mean_b <= mean_q;
                    r_acc    <= '0;
                end
            end
            S_PASS: begin
                if (r_p1) begin
                    r_ma <= dev_a[RET_W+1] ? ndev_a[RET_W-1:0] : dev_a[RET_W-1:0];
                    r_mb <= dev_b[RET_W+1] ? ndev_b[RET_W-1:0] : dev_b[RET_W-1:0];
                    r_xn <= dev_a[RET_W+1] ^ dev_b[RET_W+1];
                end
                if (r_p2) begin
                    r_prod <= r_ma * r_mb;
                    r_pn   <= r_xn;
                end
                if (r_p3) begin
                    if (r_pn) begin
                        r_acc <= r_acc - {{(SACW-64){1'b0}}, r_prod};
                    end else begin
                        r_acc <= r_acc + {{(SACW-64){1'b0}}, r_prod};
                    end
                end
                r_ld_num <= acc_neg ? nacc[ACCW-1:0] : r_acc[ACCW-1:0];
                r_ld_den <= r_n;
                r_ld_neg <= acc_neg;
            end
            S_COV: begin
                if (ld_done) begin
                    r_cov   <= cov_val;
                    r_pairs <= PAIRS_W'(r_n);
                    r_ovf   <= r_sat | cov_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_valid;
    assign o_covariance = r_cov;
    assign o_pairs_used = r_pairs;
    assign o_overflowed = r_ovf;
endmodule
